/* src/sliding_window_statistics_core_macros.svh */
// ----------------------------------------------------------------------------
// Sliding window statistics: assertion macros
// Concurrent check helpers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_STATISTICS_CORE_MACROS_SVH
`define SLIDING_WINDOW_STATISTICS_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge out of reset.
`define SWS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sliding window statistics check failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define SWS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sliding window statistics check failed");
`else
`define SWS_ASSERT_IMPL(lbl, ante, cons)
`define SWS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/swstat_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window statistics package
// Widths, codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package swstat_pkg;

	// Store geometry and field widths.
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = 6;
	localparam int CNT_W   = 7;
	localparam int SMP_W   = 16;
	localparam int SUM_W   = 22;
	localparam int SQ_W    = 32;
	localparam int SUMSQ_W = 37;
	localparam int NUM_W   = 44;
	localparam int NSQ_W   = 13;
	localparam int VAR_W   = 31;
	localparam int DIV_CNT_W = 6;

	// Action codes carried with each input word.
	localparam logic [2:0] MODE_ADD   = 3'd0;
	localparam logic [2:0] MODE_TRIM  = 3'd1;
	localparam logic [2:0] MODE_CLEAR = 3'd2;
	localparam logic [2:0] MODE_WRITE = 3'd3;
	localparam logic [2:0] MODE_READ  = 3'd4;

	// Status codes returned with each result word.
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BAD_IDX = 2'd1;
	localparam logic [1:0] STATUS_BAD_KEEP = 2'd2;

	// Register index of the window length.
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_PREP,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic scan;
		logic prep;
		logic div_start;
		logic div_var;
		logic cap_mean;
		logic cap_var;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic empty;
		logic div_done;
	} stat_t;

	// One result word.
	typedef struct packed {
		logic [1:0]               status;
		logic [CNT_W-1:0]         count;
		logic                     full_res;
		logic signed [SMP_W-1:0]  read_value;
		logic signed [SUM_W-1:0]  window_sum;
		logic signed [SMP_W-1:0]  window_min;
		logic signed [SMP_W-1:0]  window_max;
		logic signed [SMP_W-1:0]  window_mean;
		logic [VAR_W-1:0]         window_variance;
	} res_t;

endpackage

/* src/swstat_div.sv */
// ----------------------------------------------------------------------------
// Sliding window statistics divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swstat_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [swstat_pkg::NUM_W-1:0]   dividend,
	input  logic [swstat_pkg::NSQ_W-1:0]   divisor,
	output logic                           done,
	output logic [swstat_pkg::NUM_W-1:0]   quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [swstat_pkg::DIV_CNT_W-1:0]  step_q;
	logic [swstat_pkg::NSQ_W:0]        rem_q;
	logic [swstat_pkg::NUM_W-1:0]      quo_q;
	logic [swstat_pkg::NSQ_W-1:0]      dsr_q;
	logic [swstat_pkg::NSQ_W:0]        trial;
	logic                              fits;

	// Shift in the next dividend bit and try a subtraction.
	always_comb begin
		trial = {rem_q[swstat_pkg::NSQ_W-1:0], quo_q[swstat_pkg::NUM_W-1]};
		fits  = trial >= {1'b0, dsr_q};
	end

	// Sequencing of the steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == swstat_pkg::DIV_CNT_W'(swstat_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			quo_q <= {quo_q[swstat_pkg::NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* src/swstat_dp.sv */
// ----------------------------------------------------------------------------
// Sliding window statistics datapath
// Sample store, window bookkeeping, scan accumulators and the final divides.
// ----------------------------------------------------------------------------
module swstat_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  swstat_pkg::cmd_t                     cmd,
	input  logic                                 cfg_we,
	input  logic [swstat_pkg::CNT_W-1:0]         cfg_wdata,
	input  logic [2:0]                           mode,
	input  logic signed [swstat_pkg::SMP_W-1:0]  sample,
	input  logic [swstat_pkg::ADDR_W-1:0]        keep_count,
	input  logic [swstat_pkg::ADDR_W-1:0]        index,
	output swstat_pkg::stat_t                    stat,
	output swstat_pkg::res_t                     res,
	output logic [swstat_pkg::CNT_W-1:0]         window_length
);

	// Stored item.
	logic [2:0]                           mode_q;
	logic signed [swstat_pkg::SMP_W-1:0]  smp_q;
	logic [swstat_pkg::ADDR_W-1:0]        keep_q;
	logic [swstat_pkg::ADDR_W-1:0]        idx_q;

	// Window state.
	logic [swstat_pkg::CNT_W-1:0]   wlen_q;
	logic [swstat_pkg::ADDR_W-1:0]  ptr_q;
	logic [swstat_pkg::CNT_W-1:0]   cnt_q;
	logic [1:0]                     status_q;

	// Store.
	logic signed [swstat_pkg::SMP_W-1:0]  mem [swstat_pkg::DEPTH];
	logic signed [swstat_pkg::SMP_W-1:0]  rdata_q;
	logic                                 mem_we;
	logic [swstat_pkg::ADDR_W-1:0]        mem_waddr;
	logic                                 mem_re;
	logic [swstat_pkg::ADDR_W-1:0]        mem_raddr;

	// Scan and accumulators.
	logic [swstat_pkg::CNT_W-1:0]           scan_i_q;
	logic                                   issue;
	logic                                   v1_s1;
	logic                                   v2_s2;
	logic [swstat_pkg::SQ_W-1:0]            sq_s2;
	logic                                   first_q;
	logic                                   rd_pend_q;
	logic signed [swstat_pkg::SUM_W-1:0]    sum_q;
	logic [swstat_pkg::SUMSQ_W-1:0]         sumsq_q;
	logic signed [swstat_pkg::SMP_W-1:0]    mn_q;
	logic signed [swstat_pkg::SMP_W-1:0]    mx_q;
	logic signed [swstat_pkg::SMP_W-1:0]    rdv_q;
	logic signed [swstat_pkg::SMP_W-1:0]    mean_q;
	logic [swstat_pkg::VAR_W-1:0]           var_q;

	// Final arithmetic.
	logic [swstat_pkg::NUM_W-1:0]   prod_a_q;
	logic [swstat_pkg::NUM_W-1:0]   prod_b_q;
	logic [swstat_pkg::NSQ_W-1:0]   nn_q;
	logic [swstat_pkg::NUM_W-1:0]   div_dividend;
	logic [swstat_pkg::NSQ_W-1:0]   div_divisor;
	logic                           div_done;
	logic [swstat_pkg::NUM_W-1:0]   div_quo;
	logic [swstat_pkg::SUM_W-1:0]   sum_mag;

	// Action decode.
	logic [swstat_pkg::CNT_W-1:0]   len;
	logic                           drop;
	logic [swstat_pkg::ADDR_W-1:0]  add_ptr;
	logic [swstat_pkg::CNT_W-1:0]   add_cnt;
	logic [swstat_pkg::ADDR_W-1:0]  idx_slot;
	logic                           idx_ok;
	logic                           keep_bad;
	logic [swstat_pkg::CNT_W-1:0]   trim_drop;

	// Effective window length: zero acts as one, above the depth as the depth.
	always_comb begin
		if (wlen_q == '0) begin
			len = swstat_pkg::CNT_W'(1);
		end else if (wlen_q > swstat_pkg::CNT_W'(swstat_pkg::DEPTH)) begin
			len = swstat_pkg::CNT_W'(swstat_pkg::DEPTH);
		end else begin
			len = wlen_q;
		end
	end

	// Pointer and count arithmetic for each action.
	always_comb begin
		drop      = cnt_q >= len;
		add_ptr   = drop ? ptr_q + 1'b1 : ptr_q;
		add_cnt   = drop ? len - 1'b1 : cnt_q;
		idx_slot  = ptr_q + idx_q;
		idx_ok    = {1'b0, idx_q} < cnt_q;
		keep_bad  = {1'b0, keep_q} >= len;
		trim_drop = cnt_q - {1'b0, keep_q};
		issue     = cmd.scan && (scan_i_q < cnt_q);
	end

	// Store port selection.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_slot;
		mem_re    = 1'b0;
		mem_raddr = ptr_q + scan_i_q[swstat_pkg::ADDR_W-1:0];
		if (cmd.exec) begin
			unique case (mode_q)
				swstat_pkg::MODE_ADD: begin
					mem_we    = 1'b1;
					mem_waddr = add_ptr + add_cnt[swstat_pkg::ADDR_W-1:0];
				end
				swstat_pkg::MODE_WRITE: begin
					mem_we = idx_ok;
				end
				swstat_pkg::MODE_READ: begin
					mem_re    = idx_ok;
					mem_raddr = idx_slot;
				end
				default: begin
				end
			endcase
		end else if (issue) begin
			mem_re = 1'b1;
		end
	end

	// Sample store with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= smp_q;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			smp_q  <= sample;
			keep_q <= keep_count;
			idx_q  <= index;
		end
	end

	// Window length, pointer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q   <= swstat_pkg::CNT_W'(swstat_pkg::DEPTH);
			ptr_q    <= '0;
			cnt_q    <= '0;
			status_q <= swstat_pkg::STATUS_OK;
		end else if (cfg_we) begin
			wlen_q <= cfg_wdata;
			ptr_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.exec) begin
			status_q <= swstat_pkg::STATUS_OK;
			unique case (mode_q)
				swstat_pkg::MODE_ADD: begin
					ptr_q <= add_ptr;
					cnt_q <= add_cnt + 1'b1;
				end
				swstat_pkg::MODE_TRIM: begin
					if (keep_bad) begin
						status_q <= swstat_pkg::STATUS_BAD_KEEP;
					end else if (cnt_q > {1'b0, keep_q}) begin
						ptr_q <= ptr_q + trim_drop[swstat_pkg::ADDR_W-1:0];
						cnt_q <= {1'b0, keep_q};
					end
				end
				swstat_pkg::MODE_CLEAR: begin
					ptr_q <= '0;
					cnt_q <= '0;
				end
				swstat_pkg::MODE_WRITE, swstat_pkg::MODE_READ: begin
					if (!idx_ok) begin
						status_q <= swstat_pkg::STATUS_BAD_IDX;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Scan index and pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_i_q  <= '0;
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			rd_pend_q <= 1'b0;
			first_q   <= 1'b0;
		end else begin
			v1_s1     <= issue;
			v2_s2     <= v1_s1;
			rd_pend_q <= cmd.exec && (mode_q == swstat_pkg::MODE_READ) && idx_ok;
			if (cmd.exec) begin
				scan_i_q <= '0;
				first_q  <= 1'b1;
			end else begin
				if (cmd.scan) begin
					scan_i_q <= scan_i_q + 1'b1;
				end
				if (v1_s1) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	// Accumulators, squares and the final results.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			sum_q   <= '0;
			sumsq_q <= '0;
			mn_q    <= '0;
			mx_q    <= '0;
			rdv_q   <= '0;
			mean_q  <= '0;
			var_q   <= '0;
		end else begin
			if (rd_pend_q) begin
				rdv_q <= rdata_q;
			end
			if (v1_s1) begin
				sum_q <= sum_q + swstat_pkg::SUM_W'(rdata_q);
				if (first_q || rdata_q < mn_q) begin
					mn_q <= rdata_q;
				end
				if (first_q || rdata_q > mx_q) begin
					mx_q <= rdata_q;
				end
			end
			if (v2_s2) begin
				sumsq_q <= sumsq_q + swstat_pkg::SUMSQ_W'(sq_s2);
			end
			if (cmd.cap_mean) begin
				mean_q <= sum_q[swstat_pkg::SUM_W-1] ?
					-div_quo[swstat_pkg::SMP_W-1:0] : div_quo[swstat_pkg::SMP_W-1:0];
			end
			if (cmd.cap_var) begin
				var_q <= div_quo[swstat_pkg::VAR_W-1:0];
			end
		end
		sq_s2 <= swstat_pkg::SQ_W'(rdata_q * rdata_q);
		if (cmd.prep) begin
			prod_a_q <= swstat_pkg::NUM_W'(cnt_q) * swstat_pkg::NUM_W'(sumsq_q);
			prod_b_q <= swstat_pkg::NUM_W'(sum_q * sum_q);
			nn_q     <= swstat_pkg::NSQ_W'(cnt_q * cnt_q);
		end
	end

	// Divider operands: the mean works on the magnitude of the sum.
	always_comb begin
		sum_mag = sum_q[swstat_pkg::SUM_W-1] ? -sum_q : sum_q;
		if (cmd.div_var) begin
			div_dividend = prod_a_q - prod_b_q;
			div_divisor  = nn_q;
		end else begin
			div_dividend = swstat_pkg::NUM_W'(sum_mag);
			div_divisor  = swstat_pkg::NSQ_W'(cnt_q);
		end
	end

	swstat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Status toward the controller.
	always_comb begin
		stat.scan_last = (scan_i_q + 1'b1) >= cnt_q;
		stat.empty     = cnt_q == '0;
		stat.div_done  = div_done;
	end

	// Result word.
	always_comb begin
		res.status          = status_q;
		res.count           = cnt_q;
		res.full_res        = cnt_q == len;
		res.read_value      = rdv_q;
		res.window_sum      = sum_q;
		res.window_min      = mn_q;
		res.window_max      = mx_q;
		res.window_mean     = mean_q;
		res.window_variance = var_q;
	end

	assign window_length = wlen_q;

endmodule

/* src/swstat_ctrl.sv */
// ----------------------------------------------------------------------------
// Sliding window statistics controller
// Sequences action, scan, products and, for a non-empty window, the two divides for each word.
// ----------------------------------------------------------------------------
module swstat_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_free,
	input  swstat_pkg::stat_t  stat,
	output logic               in_ready,
	output logic               out_load,
	output swstat_pkg::cmd_t   cmd
);

	swstat_pkg::state_t state_q;
	swstat_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swstat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swstat_pkg::ST_IDLE:      if (in_valid) state_d = swstat_pkg::ST_EXEC;
			swstat_pkg::ST_EXEC:      state_d = swstat_pkg::ST_SCAN;
			swstat_pkg::ST_SCAN:      if (stat.scan_last) state_d = swstat_pkg::ST_DRAIN1;
			swstat_pkg::ST_DRAIN1:    state_d = swstat_pkg::ST_DRAIN2;
			swstat_pkg::ST_DRAIN2:    state_d = swstat_pkg::ST_PREP;
			swstat_pkg::ST_PREP: begin
				state_d = stat.empty ? swstat_pkg::ST_DONE : swstat_pkg::ST_MEAN_GO;
			end
			swstat_pkg::ST_MEAN_GO:   state_d = swstat_pkg::ST_MEAN_WAIT;
			swstat_pkg::ST_MEAN_WAIT: if (stat.div_done) state_d = swstat_pkg::ST_VAR_GO;
			swstat_pkg::ST_VAR_GO:    state_d = swstat_pkg::ST_VAR_WAIT;
			swstat_pkg::ST_VAR_WAIT:  if (stat.div_done) state_d = swstat_pkg::ST_DONE;
			swstat_pkg::ST_DONE:      if (out_free) state_d = swstat_pkg::ST_IDLE;
			default:                  state_d = swstat_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready      = state_q == swstat_pkg::ST_IDLE;
		out_load      = (state_q == swstat_pkg::ST_DONE) && out_free;
		cmd.load      = in_ready && in_valid;
		cmd.exec      = state_q == swstat_pkg::ST_EXEC;
		cmd.scan      = state_q == swstat_pkg::ST_SCAN;
		cmd.prep      = state_q == swstat_pkg::ST_PREP;
		cmd.div_start = (state_q == swstat_pkg::ST_MEAN_GO) ||
		                (state_q == swstat_pkg::ST_VAR_GO);
		cmd.div_var   = state_q == swstat_pkg::ST_VAR_GO;
		cmd.cap_mean  = (state_q == swstat_pkg::ST_MEAN_WAIT) && stat.div_done;
		cmd.cap_var   = (state_q == swstat_pkg::ST_VAR_WAIT) && stat.div_done;
	end

endmodule

/* src/sliding_window_statistics_core.sv */
// ----------------------------------------------------------------------------
// Sliding window statistics core
// Windowed sum, min, max, mean and variance over signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on the s_ stream; s_tuser carries the action (add, trim,
// clear, write at index, read at index) and s_tdata the operands. Each input
// word produces exactly one result word on the m_ stream, with the status in
// m_tuser and the count, full flag, read value and statistics in m_tdata.
// One word is processed at a time. After acceptance a word passes through the
// EXEC action state; a scan that reads one stored sample per cycle through the
// single read port; the DRAIN1 and DRAIN2 pipeline states; the PREP product
// state; two 44-step divides for the mean and variance, which an empty window
// skips; and the DONE output state, which waits while the output register is full.
// The window length register sits at APB byte address 0; writing it empties
// the window. After reset the window is empty and the length is 64.
// The finished result sits in an output register; s_tready returns as soon
// as the result is loaded there, and a later result waits while m_tready is
// low.
// ----------------------------------------------------------------------------
`include "sliding_window_statistics_core_macros.svh"

module sliding_window_statistics_core (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration port.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// Input stream.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // sample[15:0], keep_count[21:16], index[27:22]
	input  logic [2:0]   s_tuser,   // mode[2:0]
	// Result stream.
	output logic         m_tvalid,
	input  logic         m_tready,
	// count[6:0], full_res[7], read_value[23:8], window_sum[45:24],
	// window_min[61:46], window_max[77:62], window_mean[93:78],
	// window_variance[124:94]
	output logic [127:0] m_tdata,
	output logic [1:0]   m_tuser    // status[1:0]
);

	swstat_pkg::cmd_t   cmd;
	swstat_pkg::stat_t  stat;
	swstat_pkg::res_t   res;
	swstat_pkg::res_t   res_q;
	logic               m_tvalid_q;
	logic               out_free;
	logic               out_load;
	logic               cfg_we;
	logic [swstat_pkg::CNT_W-1:0] wlen;

	// Register decode.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == swstat_pkg::REG_WINDOW_LENGTH);
	assign prdata = (paddr[2] == swstat_pkg::REG_WINDOW_LENGTH) ? 32'(wlen) : '0;

	assign out_free = !m_tvalid_q || m_tready;

	swstat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (s_tready),
		.out_load (out_load),
		.cmd      (cmd)
	);

	swstat_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (pwdata[swstat_pkg::CNT_W-1:0]),
		.mode          (s_tuser),
		.sample        (s_tdata[15:0]),
		.keep_count    (s_tdata[21:16]),
		.index         (s_tdata[27:22]),
		.stat          (stat),
		.res           (res),
		.window_length (wlen)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res;
		end
	end

	// Result packing.
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {3'b000, res_q.window_variance, res_q.window_mean, res_q.window_max,
	                   res_q.window_min, res_q.window_sum, res_q.read_value,
	                   res_q.full_res, res_q.count};

	// An accepted word keeps the input closed for at least the next cycle.
	`SWS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// A full window is never empty.
	`SWS_ASSERT_IMPL(a_full_not_empty, m_tvalid && res_q.full_res, res_q.count != '0)
	// The mean lies between the extremes.
	`SWS_ASSERT_IMPL(a_mean_in_range, m_tvalid,
		(res_q.window_mean >= res_q.window_min) && (res_q.window_mean <= res_q.window_max))

endmodule
